// ===== hdl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value table: widths, request codes,
// the slot entry layout, the scan summary and the sequencer states.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int KVT_CAPACITY = 64;
	localparam int ACT_W        = 2;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;
	localparam int RES_W        = 33;
	localparam int COUNT_W      = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_MAXMIN = 2'd3
	} act_t;

	typedef struct packed {
		logic                    used;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic                    hit;
		logic                    has_free;
		logic                    nonempty;
		logic signed [VAL_W-1:0] hit_val;
		logic signed [VAL_W-1:0] min_val;
		logic signed [VAL_W-1:0] max_val;
	} scan_res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/kvt_mem.sv =====
// ----------------------------------------------------------------------------
// kvt_mem
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kvt_mem
	import kvt_pkg::*;
#(
	parameter int DEPTH = KVT_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/kvt_scan.sv =====
// ----------------------------------------------------------------------------
// kvt_scan
// Shared compare unit: takes one slot per cycle while en is high; tracks the
// matching slot, lowest free slot and entries at the smallest and largest key.
// ----------------------------------------------------------------------------
module kvt_scan
	import kvt_pkg::*;
#(
	parameter int AW = $clog2(KVT_CAPACITY)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    en,
	input  entry_t                  ent,
	input  logic [AW-1:0]           idx,
	input  logic signed [KEY_W-1:0] query,
	output scan_res_t               res,
	output logic [AW-1:0]           hit_idx,
	output logic [AW-1:0]           free_idx
);

	logic                    hit_q;
	logic                    has_free_q;
	logic                    nonempty_q;
	logic signed [VAL_W-1:0] hit_val_q;
	logic signed [KEY_W-1:0] min_key_q;
	logic signed [KEY_W-1:0] max_key_q;
	logic signed [VAL_W-1:0] min_val_q;
	logic signed [VAL_W-1:0] max_val_q;
	logic [AW-1:0]           hit_idx_q;
	logic [AW-1:0]           free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			has_free_q <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (start) begin
			hit_q      <= 1'b0;
			has_free_q <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (en) begin
			if (ent.used && (ent.key == query)) begin
				hit_q <= 1'b1;
			end
			if (!ent.used) begin
				has_free_q <= 1'b1;
			end
			if (ent.used) begin
				nonempty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ent.used && (ent.key == query) && !hit_q) begin
				hit_idx_q <= idx;
				hit_val_q <= ent.value;
			end
			if (!ent.used && !has_free_q) begin
				free_idx_q <= idx;
			end
			if (ent.used && (!nonempty_q || (ent.key < min_key_q))) begin
				min_key_q <= ent.key;
				min_val_q <= ent.value;
			end
			if (ent.used && (!nonempty_q || (ent.key > max_key_q))) begin
				max_key_q <= ent.key;
				max_val_q <= ent.value;
			end
		end
	end

	always_comb begin
		res.hit      = hit_q;
		res.has_free = has_free_q;
		res.nonempty = nonempty_q;
		res.hit_val  = hit_val_q;
		res.min_val  = min_val_q;
		res.max_val  = max_val_q;
	end

	assign hit_idx  = hit_idx_q;
	assign free_idx = free_idx_q;

endmodule

// ===== hdl/key_value_table.sv =====
// ----------------------------------------------------------------------------
// key_value_table
// Fixed-capacity map from unique signed keys to signed values: insert or
// update, lookup, remove, and value at largest key minus value at smallest.
//
//   channel | signals                                  | beat
//   --------+------------------------------------------+-------------------
//   in      | in_valid, in_stall, action, key, value   | one request
//   out     | out_valid, out_stall, found,             | one result per
//           | result_value, entry_count, table_full    | request
//
// Each request scans all CAPACITY slots through one read port, one slot per
// cycle, then passes through an update state; no new request is accepted
// until the result has been loaded into the output register.
// After reset a clearing pass over all CAPACITY slots marks every slot free; no
// request is accepted meanwhile.
// A stalled result holds in the output register; the next request is
// accepted while it waits.
// ----------------------------------------------------------------------------
module key_value_table
	import kvt_pkg::*;
#(
	parameter int CAPACITY = KVT_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ACT_W-1:0]        action,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    found,
	output logic signed [RES_W-1:0] result_value,
	output logic [COUNT_W-1:0]      entry_count,
	output logic                    table_full
);

	localparam int          AW        = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

	state_t                  state_q;
	state_t                  state_d;
	logic [AW-1:0]           addr_q;
	act_t                    act_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    rd_vld_s1;
	logic [AW-1:0]           rd_idx_s1;
	logic [COUNT_W-1:0]      count_q;

	logic                    res_found_q;
	logic signed [RES_W-1:0] res_value_q;
	logic                    res_full_q;

	logic                    out_valid_q;
	logic                    out_found_q;
	logic signed [RES_W-1:0] out_value_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic                    out_full_q;

	logic                    accept;
	logic                    out_load;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	entry_t                  mem_wdata;
	entry_t                  mem_rdata;

	scan_res_t               scan;
	logic [AW-1:0]           hit_idx;
	logic [AW-1:0]           free_idx;

	logic                    upd_we;
	logic [AW-1:0]           upd_waddr;
	entry_t                  upd_wdata;
	logic                    upd_found;
	logic signed [RES_W-1:0] upd_value;
	logic                    upd_full;
	logic [COUNT_W-1:0]      upd_count;

	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	kvt_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	kvt_scan #(
		.AW (AW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.en       (rd_vld_s1),
		.ent      (mem_rdata),
		.idx      (rd_idx_s1),
		.query    (key_q),
		.res      (scan),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_stall        = 1'b1;
		mem_we          = 1'b0;
		mem_waddr       = addr_q;
		mem_wdata.used  = 1'b0;
		mem_wdata.key   = '0;
		mem_wdata.value = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				mem_we    = upd_we;
				mem_waddr = upd_waddr;
				mem_wdata = upd_wdata;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		upd_we          = 1'b0;
		upd_waddr       = hit_idx;
		upd_wdata.used  = 1'b1;
		upd_wdata.key   = key_q;
		upd_wdata.value = val_q;
		upd_found       = 1'b0;
		upd_value       = '0;
		upd_full        = 1'b0;
		upd_count       = count_q;
		unique case (act_q)
			ACT_INSERT: begin
				if (scan.hit) begin
					upd_we    = 1'b1;
					upd_found = 1'b1;
					upd_value = RES_W'(scan.hit_val);
				end else if (scan.has_free) begin
					upd_we    = 1'b1;
					upd_waddr = free_idx;
					upd_count = count_q + 1'b1;
				end else begin
					upd_full = 1'b1;
				end
			end
			ACT_LOOKUP: begin
				if (scan.hit) begin
					upd_found = 1'b1;
					upd_value = RES_W'(scan.hit_val);
				end
			end
			ACT_REMOVE: begin
				if (scan.hit) begin
					upd_we         = 1'b1;
					upd_wdata.used = 1'b0;
					upd_found      = 1'b1;
					upd_value      = RES_W'(scan.hit_val);
					upd_count      = count_q - 1'b1;
				end
			end
			ACT_MAXMIN: begin
				if (scan.nonempty) begin
					upd_found = 1'b1;
					upd_value = RES_W'(scan.max_val) - RES_W'(scan.min_val);
				end
			end
			default: begin
				upd_found = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_CLEAR) || (state_q == ST_SCAN)) begin
				if (addr_q == LAST_ADDR) begin
					addr_q <= '0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (state_q == ST_UPDATE) begin
				count_q <= upd_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (accept) begin
			act_q <= act_t'(action);
			key_q <= key;
			val_q <= value;
		end
		if (state_q == ST_UPDATE) begin
			res_found_q <= upd_found;
			res_value_q <= upd_value;
			res_full_q  <= upd_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= res_found_q;
			out_value_q <= res_value_q;
			out_count_q <= count_q;
			out_full_q  <= res_full_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign result_value = out_value_q;
	assign entry_count  = out_count_q;
	assign table_full   = out_full_q;

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(table_full && found))
		else $error("rejected insert reports a found key");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (result_value == '0))
		else $error("miss result carries a nonzero value");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |->
			((CAPACITY > 127) || (entry_count == COUNT_W'(CAPACITY))))
		else $error("table reported full below capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted while a scan is running");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for key_value_table. A directed sweep covers key and
// value extremes, every request kind, the empty and single-entry table,
// update in place and slot reuse. After it come segments of random requests
// that fill, drain and churn a small key pool, so the table runs full and
// empty many times. A shadow slot store predicts each result beat that the
// plan does not give by hand. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import kvt_pkg::*;

	localparam int POOL_SIZE      = 68;
	localparam int RANDOM_ITEMS   = 930;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic                    found;
		logic signed [RES_W-1:0] value;
		logic [COUNT_W-1:0]      count;
		logic                    full;
	} kv_res_t;

	typedef struct packed {
		act_t             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             typed;
		kv_res_t          res;
	} kv_row_t;

	typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [ACT_W-1:0]        action = ACT_INSERT;
	logic signed [KEY_W-1:0] key = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    found;
	logic signed [RES_W-1:0] result_value;
	logic [COUNT_W-1:0]      entry_count;
	logic                    table_full;

	logic signed [KEY_W-1:0] shadow_key [KVT_CAPACITY];
	logic signed [VAL_W-1:0] shadow_val [KVT_CAPACITY];
	bit                      shadow_used [KVT_CAPACITY];
	int                      shadow_count = 0;
	kv_res_t                 pending_results [$];
	int                      mismatch_count = 0;
	int                      idle_cycles = 0;
	int                      stall_left = 0;
	bit                      steady = 1'b0;

	kv_row_t plan [21] = '{
		'{ACT_MAXMIN, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 33'h0_0000_0000, 7'd0, 1'b0}},
		'{ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 33'h0_0000_0000, 7'd0, 1'b0}},
		'{ACT_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 33'h0_0000_0000, 7'd0, 1'b0}},
		'{ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 33'h0_0000_0000, 7'd1, 1'b0}},
		'{ACT_MAXMIN, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 33'h0_0000_0000, 7'd1, 1'b0}},
		'{ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 33'h0_0000_0000, 7'd2, 1'b0}},
		'{ACT_MAXMIN, 32'h1234_5678, 32'h0000_0000, 1'b1, '{1'b1, 33'h1_0000_0001, 7'd2, 1'b0}},
		'{ACT_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 33'h0_7FFF_FFFF, 7'd2, 1'b0}},
		'{ACT_LOOKUP, 32'h8000_0000, 32'hDEAD_BEEF, 1'b1, '{1'b1, 33'h1_FFFF_FFFF, 7'd2, 1'b0}},
		'{ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ACT_INSERT, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0, '0},
		'{ACT_INSERT, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0, '0},
		'{ACT_MAXMIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ACT_REMOVE, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b1, '{1'b1, 33'h1_8000_0000, 7'd4, 1'b0}},
		'{ACT_MAXMIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 33'h0_0000_0000, 7'd4, 1'b0}},
		'{ACT_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 33'h1_FFFF_FFFF, 7'd3, 1'b0}},
		'{ACT_INSERT, 32'h8000_0000, 32'h0000_0007, 1'b0, '0},
		'{ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{ACT_INSERT, 32'h1234_5678, 32'hEDCB_A987, 1'b0, '0},
		'{ACT_MAXMIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
	};

	key_value_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.result_value(result_value),
		.entry_count (entry_count),
		.table_full  (table_full)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic kv_res_t apply_request(act_t act, logic signed [KEY_W-1:0] k,
			logic signed [VAL_W-1:0] v);
		kv_res_t r;
		int hit, free_slot, lo, hi;
		logic signed [RES_W-1:0] hi_val, lo_val;
		r = '0;
		hit = -1;
		free_slot = -1;
		lo = -1;
		hi = -1;
		for (int i = 0; i < KVT_CAPACITY; i++) begin
			if (!shadow_used[i]) begin
				if (free_slot < 0)
					free_slot = i;
			end else begin
				if (hit < 0 && shadow_key[i] == k)
					hit = i;
				if (lo < 0 || shadow_key[i] < shadow_key[lo])
					lo = i;
				if (hi < 0 || shadow_key[i] > shadow_key[hi])
					hi = i;
			end
		end
		unique case (act)
			ACT_INSERT: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.value = RES_W'(shadow_val[hit]);
					shadow_val[hit] = v;
				end else if (free_slot >= 0) begin
					shadow_used[free_slot] = 1'b1;
					shadow_key[free_slot] = k;
					shadow_val[free_slot] = v;
					shadow_count++;
				end else
					r.full = 1'b1;
			end
			ACT_LOOKUP, ACT_REMOVE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					r.value = RES_W'(shadow_val[hit]);
					if (act == ACT_REMOVE) begin
						shadow_used[hit] = 1'b0;
						shadow_count--;
					end
				end
			end
			default: begin
				if (lo >= 0) begin
					hi_val = RES_W'(shadow_val[hi]);
					lo_val = RES_W'(shadow_val[lo]);
					r.found = 1'b1;
					r.value = hi_val - lo_val;
				end
			end
		endcase
		r.count = COUNT_W'(shadow_count);
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 90);
	endfunction

	task automatic send_beat(act_t act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic typed, kv_res_t typed_res);
		int gap;
		kv_res_t r;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_stall);
		r = apply_request(act, k, v);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// hold the sender until every pending result beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		kv_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					mismatch_count++;
				end
				if (result_value !== want.value) begin
					$error("result_value: expected %0d, got %0d", want.value, result_value);
					mismatch_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					mismatch_count++;
				end
				if (table_full !== want.full) begin
					$error("table_full: expected %0d, got %0d", want.full, table_full);
					mismatch_count++;
				end
			end
		end
		if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = idle_len();
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("key_value_table verification failed");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0] pool [POOL_SIZE];
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		int sent, seg_len, cursor, pick;
		seg_t seg;
		act_t act;
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = $urandom();
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		pool[2] = 32'h0000_0000;
		pool[3] = 32'hFFFF_FFFF;
		sent = 0;
		cursor = 0;
		seg = SEG_FILL;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_beat(plan[i].act, plan[i].key, plan[i].value, plan[i].typed, plan[i].res);
		drain_results();

		while (sent < RANDOM_ITEMS) begin
			seg_len = (sent == 0) ? 150 : $urandom_range(40, 150);
			if (seg_len > RANDOM_ITEMS - sent)
				seg_len = RANDOM_ITEMS - sent;
			steady = (sent != 0) && ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				pick = $urandom_range(0, 99);
				unique case (seg)
					SEG_FILL: act = pick < 80 ? ACT_INSERT : pick < 88 ? ACT_LOOKUP :
						pick < 94 ? ACT_REMOVE : ACT_MAXMIN;
					SEG_DRAIN: act = pick < 12 ? ACT_INSERT : pick < 22 ? ACT_LOOKUP :
						pick < 85 ? ACT_REMOVE : ACT_MAXMIN;
					default: act = pick < 25 ? ACT_INSERT : pick < 50 ? ACT_LOOKUP :
						pick < 75 ? ACT_REMOVE : ACT_MAXMIN;
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 12)
					k = $urandom();
				else if (pick < 80 && ((seg == SEG_FILL && act == ACT_INSERT) ||
						(seg == SEG_DRAIN && act == ACT_REMOVE))) begin
					k = pool[cursor];
					cursor = (cursor + 1) % POOL_SIZE;
				end else
					k = pool[$urandom_range(0, POOL_SIZE - 1)];
				pick = $urandom_range(0, 9);
				v = pick == 0 ? 32'h8000_0000 : pick == 1 ? 32'h7FFF_FFFF : $urandom();
				send_beat(act, k, v, 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				drain_results();
			seg = seg_t'($urandom_range(0, 2));
		end
		steady = 1'b0;

		drain_results();
		repeat (KVT_CAPACITY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("key_value_table verification clean");
		else
			$display("key_value_table verification failed");
		$finish;
	end

endmodule
